// File: hw/rtl/i2cmbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types, register map, command codes and helpers.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

  localparam int TICK_BITS = 16;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_BITS) - 64'd1);

  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_START = 3'd1,
    REQ_TX    = 3'd2,
    REQ_WACK  = 3'd3,
    REQ_RX    = 3'd4,
    REQ_ACK   = 3'd5,
    REQ_NACK  = 3'd6,
    REQ_STOP  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    REG_HALF_BIT   = 3'd0,
    REG_SETTLE     = 3'd1,
    REG_ACK_SETUP  = 3'd2,
    REG_STOP_SETUP = 3'd3,
    REG_POLL_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_SETTLE = 5'd1,
    PH_ST_HOLD   = 5'd2,
    PH_TX_PRE    = 5'd3,
    PH_TX_HIGH   = 5'd4,
    PH_TX_LOW    = 5'd5,
    PH_WA        = 5'd6,
    PH_RX_PRE    = 5'd7,
    PH_RX_LOW    = 5'd8,
    PH_RX_HIGH   = 5'd9,
    PH_AK_LOW    = 5'd10,
    PH_AK_SETUP  = 5'd11,
    PH_AK_HIGH   = 5'd12,
    PH_SP_A      = 5'd13,
    PH_SP_B      = 5'd14,
    PH_SP_C      = 5'd15,
    PH_SP_D      = 5'd16
  } phase_t;

  localparam logic [15:0] RST_HALF_BIT   = 16'd50;
  localparam logic [15:0] RST_SETTLE     = 16'd50;
  localparam logic [15:0] RST_ACK_SETUP  = 16'd20;
  localparam logic [15:0] RST_STOP_SETUP = 16'd2;
  localparam logic [7:0]  RST_POLL_LIMIT = 8'd250;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] ack_setup_ticks;
    logic [15:0] stop_setup_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } res_t;

  // zero counts as one tick, saturate at the counter range
  function automatic logic [TICK_BITS-1:0] wait_ticks(input logic [15:0] r);
    logic [31:0] v;
    v = (r == 16'd0) ? 32'd1 : {16'd0, r};
    if (v > TICK_MAX) v = TICK_MAX;
    wait_ticks = v[TICK_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/i2cmbs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer configuration registers
// APB-style register file holding the delay and poll-limit settings.
// ----------------------------------------------------------------------------
module i2cmbs_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cmbs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [i2cmbs_pkg::DATA_BITS-1:0] pwdata,
  output logic [i2cmbs_pkg::DATA_BITS-1:0] prdata,
  output logic                             pready,
  output i2cmbs_pkg::cfg_t                 cfg
);

  i2cmbs_pkg::cfg_t     cfg_r;
  i2cmbs_pkg::reg_idx_t idx;
  logic                 wr_en;

  assign idx    = i2cmbs_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks   <= i2cmbs_pkg::RST_HALF_BIT;
      cfg_r.settle_ticks     <= i2cmbs_pkg::RST_SETTLE;
      cfg_r.ack_setup_ticks  <= i2cmbs_pkg::RST_ACK_SETUP;
      cfg_r.stop_setup_ticks <= i2cmbs_pkg::RST_STOP_SETUP;
      cfg_r.ack_poll_limit   <= i2cmbs_pkg::RST_POLL_LIMIT;
    end else if (wr_en) begin
      case (idx)
        i2cmbs_pkg::REG_HALF_BIT:   cfg_r.half_bit_ticks   <= pwdata[15:0];
        i2cmbs_pkg::REG_SETTLE:     cfg_r.settle_ticks     <= pwdata[15:0];
        i2cmbs_pkg::REG_ACK_SETUP:  cfg_r.ack_setup_ticks  <= pwdata[15:0];
        i2cmbs_pkg::REG_STOP_SETUP: cfg_r.stop_setup_ticks <= pwdata[15:0];
        i2cmbs_pkg::REG_POLL_LIMIT: cfg_r.ack_poll_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      i2cmbs_pkg::REG_HALF_BIT:   prdata = {16'd0, cfg_r.half_bit_ticks};
      i2cmbs_pkg::REG_SETTLE:     prdata = {16'd0, cfg_r.settle_ticks};
      i2cmbs_pkg::REG_ACK_SETUP:  prdata = {16'd0, cfg_r.ack_setup_ticks};
      i2cmbs_pkg::REG_STOP_SETUP: prdata = {16'd0, cfg_r.stop_setup_ticks};
      i2cmbs_pkg::REG_POLL_LIMIT: prdata = {24'd0, cfg_r.ack_poll_limit};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/i2cmbs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Phase machine and pin state, advanced by one tick per accepted beat.
// ----------------------------------------------------------------------------
module i2cmbs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [2:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic              sda_in,
  input  i2cmbs_pkg::cfg_t  cfg,
  output i2cmbs_pkg::res_t  res
);

  i2cmbs_pkg::phase_t              phase_r, phase_nxt;
  logic [3:0]                      bit_index_r, bit_index_nxt;
  logic [i2cmbs_pkg::TICK_BITS-1:0] delay_r, delay_nxt;
  logic [7:0]                      shift_r, shift_nxt;
  logic [7:0]                      poll_r, poll_nxt;
  logic                            scl_r, scl_nxt;
  logic                            sda_r, sda_nxt;
  logic                            en_r, en_nxt;
  logic [7:0]                      rcv_r, rcv_nxt;
  logic                            fail_r, fail_nxt;

  i2cmbs_pkg::req_t                req;
  logic                            active;
  logic                            expire;
  logic [3:0]                      bi_inc;
  logic                            poll_over;
  logic [7:0]                      rx_shift;
  logic [i2cmbs_pkg::TICK_BITS-1:0] w_half, w_settle, w_ack, w_stop;

  assign req       = i2cmbs_pkg::req_t'(req_type);
  assign active    = (phase_r != i2cmbs_pkg::PH_IDLE) && (phase_r <= i2cmbs_pkg::PH_SP_D);
  assign expire    = active && (delay_r <= i2cmbs_pkg::TICK_BITS'(1));
  assign bi_inc    = bit_index_r + 4'd1;
  assign poll_over = ({1'b0, poll_r} + 9'd1) > {1'b0, cfg.ack_poll_limit};
  assign rx_shift  = {shift_r[6:0], sda_in};
  assign w_half    = i2cmbs_pkg::wait_ticks(cfg.half_bit_ticks);
  assign w_settle  = i2cmbs_pkg::wait_ticks(cfg.settle_ticks);
  assign w_ack     = i2cmbs_pkg::wait_ticks(cfg.ack_setup_ticks);
  assign w_stop    = i2cmbs_pkg::wait_ticks(cfg.stop_setup_ticks);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r == i2cmbs_pkg::PH_IDLE) begin
      unique case (req)
        i2cmbs_pkg::REQ_START: phase_nxt = i2cmbs_pkg::PH_ST_SETTLE;
        i2cmbs_pkg::REQ_TX:    phase_nxt = i2cmbs_pkg::PH_TX_PRE;
        i2cmbs_pkg::REQ_WACK:  phase_nxt = i2cmbs_pkg::PH_WA;
        i2cmbs_pkg::REQ_RX:    phase_nxt = i2cmbs_pkg::PH_RX_PRE;
        i2cmbs_pkg::REQ_ACK,
        i2cmbs_pkg::REQ_NACK:  phase_nxt = i2cmbs_pkg::PH_AK_LOW;
        i2cmbs_pkg::REQ_STOP:  phase_nxt = i2cmbs_pkg::PH_SP_A;
        i2cmbs_pkg::REQ_NONE:  phase_nxt = i2cmbs_pkg::PH_IDLE;
      endcase
    end else if (!active) begin
      phase_nxt = i2cmbs_pkg::PH_IDLE;
    end else if (expire) begin
      case (phase_r)
        i2cmbs_pkg::PH_ST_SETTLE: phase_nxt = i2cmbs_pkg::PH_ST_HOLD;
        i2cmbs_pkg::PH_TX_PRE:    phase_nxt = i2cmbs_pkg::PH_TX_HIGH;
        i2cmbs_pkg::PH_TX_HIGH:   phase_nxt = i2cmbs_pkg::PH_TX_LOW;
        i2cmbs_pkg::PH_TX_LOW:
          phase_nxt = bit_index_r[3] ? i2cmbs_pkg::PH_IDLE : i2cmbs_pkg::PH_TX_HIGH;
        i2cmbs_pkg::PH_WA: begin
          if (!sda_in)        phase_nxt = i2cmbs_pkg::PH_IDLE;
          else if (poll_over) phase_nxt = i2cmbs_pkg::PH_SP_A;
          else                phase_nxt = i2cmbs_pkg::PH_WA;
        end
        i2cmbs_pkg::PH_RX_PRE:    phase_nxt = i2cmbs_pkg::PH_RX_LOW;
        i2cmbs_pkg::PH_RX_LOW:    phase_nxt = i2cmbs_pkg::PH_RX_HIGH;
        i2cmbs_pkg::PH_RX_HIGH:
          phase_nxt = bi_inc[3] ? i2cmbs_pkg::PH_IDLE : i2cmbs_pkg::PH_RX_LOW;
        i2cmbs_pkg::PH_AK_LOW:    phase_nxt = i2cmbs_pkg::PH_AK_SETUP;
        i2cmbs_pkg::PH_AK_SETUP:  phase_nxt = i2cmbs_pkg::PH_AK_HIGH;
        i2cmbs_pkg::PH_SP_A:      phase_nxt = i2cmbs_pkg::PH_SP_B;
        i2cmbs_pkg::PH_SP_B:      phase_nxt = i2cmbs_pkg::PH_SP_C;
        i2cmbs_pkg::PH_SP_C:      phase_nxt = i2cmbs_pkg::PH_SP_D;
        default:                  phase_nxt = i2cmbs_pkg::PH_IDLE;
      endcase
    end
  end

  // pin levels, counters and shift register
  always_comb begin
    bit_index_nxt = bit_index_r;
    delay_nxt     = delay_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    en_nxt        = en_r;
    rcv_nxt       = rcv_r;
    fail_nxt      = fail_r;
    if (phase_r == i2cmbs_pkg::PH_IDLE) begin
      unique case (req)
        i2cmbs_pkg::REQ_START: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b1; delay_nxt = w_settle;
        end
        i2cmbs_pkg::REQ_TX: begin
          scl_nxt = 1'b0; en_nxt = 1'b1; shift_nxt = tx_byte; bit_index_nxt = 4'd0;
          delay_nxt = w_half;
        end
        i2cmbs_pkg::REQ_WACK: begin
          sda_nxt = 1'b1; en_nxt = 1'b0; scl_nxt = 1'b1; poll_nxt = 8'd0;
          delay_nxt = w_half;
        end
        i2cmbs_pkg::REQ_RX: begin
          scl_nxt = 1'b0; en_nxt = 1'b0; shift_nxt = 8'd0; bit_index_nxt = 4'd0;
          delay_nxt = w_settle;
        end
        i2cmbs_pkg::REQ_ACK,
        i2cmbs_pkg::REQ_NACK: begin
          scl_nxt   = 1'b0;
          shift_nxt = (req == i2cmbs_pkg::REQ_NACK) ? 8'd1 : 8'd0;
          delay_nxt = w_half;
        end
        i2cmbs_pkg::REQ_STOP: begin
          scl_nxt = 1'b0; delay_nxt = w_stop;
        end
        i2cmbs_pkg::REQ_NONE: ;
      endcase
    end else if (active && !expire) begin
      delay_nxt = delay_r - i2cmbs_pkg::TICK_BITS'(1);
    end else if (expire) begin
      delay_nxt = '0;
      case (phase_r)
        i2cmbs_pkg::PH_ST_SETTLE: begin
          sda_nxt = 1'b0; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_ST_HOLD: scl_nxt = 1'b0;
        i2cmbs_pkg::PH_TX_PRE: begin
          sda_nxt = shift_r[7]; shift_nxt = {shift_r[6:0], 1'b0}; scl_nxt = 1'b1;
          delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_TX_HIGH: begin
          scl_nxt = 1'b0; bit_index_nxt = bi_inc; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_TX_LOW: begin
          if (!bit_index_r[3]) begin
            sda_nxt = shift_r[7]; shift_nxt = {shift_r[6:0], 1'b0}; scl_nxt = 1'b1;
            delay_nxt = w_half;
          end
        end
        i2cmbs_pkg::PH_WA: begin
          if (!sda_in) begin
            fail_nxt = 1'b0;
          end else if (poll_over) begin
            fail_nxt = 1'b1; scl_nxt = 1'b0; delay_nxt = w_stop;
          end else begin
            poll_nxt = poll_r + 8'd1; delay_nxt = w_half;
          end
        end
        i2cmbs_pkg::PH_RX_PRE: begin
          scl_nxt = 1'b0; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_RX_LOW: begin
          scl_nxt = 1'b1; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_RX_HIGH: begin
          shift_nxt     = rx_shift;
          bit_index_nxt = bi_inc;
          if (bi_inc[3]) begin
            rcv_nxt = rx_shift;
          end else begin
            scl_nxt = 1'b0; delay_nxt = w_half;
          end
        end
        i2cmbs_pkg::PH_AK_LOW: begin
          sda_nxt = shift_r[0]; en_nxt = 1'b1; delay_nxt = w_ack;
        end
        i2cmbs_pkg::PH_AK_SETUP: begin
          scl_nxt = 1'b1; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_SP_A: begin
          sda_nxt = 1'b0; en_nxt = 1'b1; delay_nxt = w_stop;
        end
        i2cmbs_pkg::PH_SP_B: begin
          scl_nxt = 1'b1; delay_nxt = w_half;
        end
        i2cmbs_pkg::PH_SP_C: begin
          sda_nxt = 1'b1; delay_nxt = w_settle;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.sda_drive = en_nxt;
    res.busy_res  = (phase_nxt != i2cmbs_pkg::PH_IDLE);
    res.done_res  = expire && (phase_nxt == i2cmbs_pkg::PH_IDLE);
    res.rx_byte   = rcv_nxt;
    res.ack_fail  = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cmbs_pkg::PH_IDLE;
      bit_index_r <= 4'd0;
      delay_r     <= '0;
      shift_r     <= 8'd0;
      poll_r      <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      en_r        <= 1'b1;
      rcv_r       <= 8'd0;
      fail_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      delay_r     <= delay_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      en_r        <= en_nxt;
      rcv_r       <= rcv_nxt;
      fail_r      <= fail_nxt;
    end
  end

endmodule

// File: hw/rtl/i2cmbs_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer result buffer
// Output register with a skid stage so a stalled beat does not block input.
// ----------------------------------------------------------------------------
module i2cmbs_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cmbs_pkg::res_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cmbs_pkg::res_t out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  i2cmbs_pkg::res_t out_data_r, out_data_nxt;
  i2cmbs_pkg::res_t skid_data_r, skid_data_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || push;
      out_data_nxt   = skid_valid_r ? skid_data_r : push_data;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: hw/rtl/i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Drives SCL and SDA for start, byte transfer, ack and stop commands.
// ----------------------------------------------------------------------------
// Each input beat is one timing tick carrying a command code (taken only
// while idle), the byte to send and the sampled SDA level. Every accepted
// beat produces exactly one result beat with the pin levels, busy, a done
// pulse, the last read byte and the ack-failure flag after that tick.
// Results are registered in the output register, or in the skid stage
// while the output is stalled. Throughput: one beat per cycle while
// in_stall is low; the phase machine and pin state update once per tick.
// When out_stall holds the output register, a skid stage takes one more
// beat; in_stall rises only while that skid stage is occupied.
// Reset (rst_n low, synchronous) returns the sequencer to idle with SCL,
// SDA and drive high, clears counters and flags, empties the result
// buffer and restores the delay registers to their defaults.
// Registers (APB, byte address 4*i): half-bit ticks, settle ticks, ack
// setup ticks, stop setup ticks, ack poll limit. Write them while idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_req_type,
  input  logic [7:0]                       in_tx_byte,
  input  logic                             in_sda_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_scl_out,
  output logic                             out_sda_out,
  output logic                             out_sda_drive,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [7:0]                       out_rx_byte,
  output logic                             out_ack_fail,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cmbs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [i2cmbs_pkg::DATA_BITS-1:0] pwdata,
  output logic [i2cmbs_pkg::DATA_BITS-1:0] prdata,
  output logic                             pready
);

  i2cmbs_pkg::cfg_t cfg;
  i2cmbs_pkg::res_t res;
  i2cmbs_pkg::res_t out_data;
  logic             buf_full;
  logic             accept;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  i2cmbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cmbs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .req_type (in_req_type),
    .tx_byte  (in_tx_byte),
    .sda_in   (in_sda_in),
    .cfg      (cfg),
    .res      (res)
  );

  i2cmbs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_scl_out   = out_data.scl_out;
  assign out_sda_out   = out_data.sda_out;
  assign out_sda_drive = out_data.sda_drive;
  assign out_busy_res  = out_data.busy_res;
  assign out_done_res  = out_data.done_res;
  assign out_rx_byte   = out_data.rx_byte;
  assign out_ack_fail  = out_data.ack_fail;

endmodule
